// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Opcodes carried by an input transaction
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [2:0] OP_DUMP_REV   = 3'd5;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Input transaction payload
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic signed [31:0] value_res;
        logic [1:0]         status;
        logic               has_value;
        logic               last;
    } t_out;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit values held in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one opcode and
//   value per transaction. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns results through a single output register.
//   Push and pop: one status result, loaded into the output register at
//   acceptance; a new transaction is taken every cycle while the receiver keeps up.
//   Dump of N elements: N results, one per cycle while the receiver keeps
//   up; the first passes through the registered RAM read, then the output
//   register; input is held off until the last one is in the output register.
//   Empty dump, empty pop, full push and unused opcodes give one result.
//   Reset empties the deque and the output register; RAM contents are not
//   cleared (only written slots are ever read).
//   When the receiver stalls, the output register holds its result and both
//   input acceptance and the dump sequence pause until it drains.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Ring slot of (front + offset) mod DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic          r_rev,   n_rev;
    logic          r_out_valid, n_out_valid;
    t_out          r_out,   n_out;

    logic          w_out_free;
    logic          w_accept;
    logic [CW-1:0] w_idx_inc;
    logic [CW-1:0] w_rd_k;
    logic          w_rd_rev;
    logic [CW-1:0] w_rd_off;
    logic [AW-1:0] w_front_dec;
    logic [AW-1:0] w_front_inc;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Ring pointer arithmetic
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    // Dump read address: first element at acceptance, next one while dumping
    assign w_idx_inc = r_idx + CW'(1);
    assign w_rd_k    = (r_state == ST_IDLE) ? '0 : w_idx_inc;
    assign w_rd_rev  = (r_state == ST_IDLE) ? (i_in_data.opcode == OP_DUMP_REV) : r_rev;
    assign w_rd_off  = w_rd_rev ? (r_count - CW'(1) - w_rd_k) : w_rd_k;
    assign rd_addr   = slot_of(r_front, w_rd_off[AW-1:0]);

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rev       = r_rev;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = slot_of(r_front, r_count[AW-1:0]);
        rd_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid     = 1'b1;
                    n_out.value_res = '0;
                    n_out.status    = STS_OK;
                    n_out.has_value = 1'b0;
                    n_out.last      = 1'b1;
                    unique case (i_in_data.opcode) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_out.status = STS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in_data.opcode == OP_PUSH_FRONT) begin
                                    wr_addr = w_front_dec;
                                    n_front = w_front_dec;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (i_in_data.opcode == OP_POP_FRONT) begin
                                    n_front = w_front_inc;
                                end
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_REV: begin
                            if (r_count == '0) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                // Start streaming: first read issued now
                                n_out_valid = 1'b0;
                                rd_en       = 1'b1;
                                n_idx       = '0;
                                n_rev       = w_rd_rev;
                                n_state     = ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.value_res = signed'(rd_data);
                    n_out.status    = STS_OK;
                    n_out.has_value = 1'b1;
                    n_out.last      = (w_idx_inc == r_count);
                    if (w_idx_inc == r_count) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = w_idx_inc;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== verif/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the bounded deque. A behavioral ring model predicts
// every result transaction; results are checked field by field, in order.
// Directed checks of empty and spare-opcode handling and of extreme values
// come first, then fill/drain sequences with full-deque overflow and random
// mixes under four sender/receiver idle profiles.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit
    import deq_pkg::*;
();

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);

    // Opcodes the block does not define; it answers them with a plain ok
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // Ring model of the deque contents
    logic [31:0]      ring_store [DEPTH];
    logic [IDX_W-1:0] ring_front;
    logic [IDX_W:0]   ring_count;

    // Results predicted but not yet seen, oldest first
    t_out pending_results[$];

    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 100 MHz clock
    always #5 i_clk = ~i_clk;

    // Run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Queue one expected result
    function automatic void expect_result(logic [31:0] val, logic [1:0] sts,
                                          logic has, logic fin);
        t_out r;
        r.value_res = val;
        r.status    = sts;
        r.has_value = has;
        r.last      = fin;
        pending_results.push_back(r);
    endfunction

    // Advance the ring model by one accepted transaction
    function automatic void predict_deque(t_in item);
        int off;
        int cnt;
        cnt = int'(ring_count);
        case (item.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (cnt >= DEPTH) begin
                    expect_result('0, STS_FULL, 1'b0, 1'b1);
                end else begin
                    if (item.opcode == OP_PUSH_FRONT) begin
                        ring_front = IDX_W'((int'(ring_front) + DEPTH - 1) % DEPTH);
                        ring_store[ring_front] = item.value;
                    end else begin
                        ring_store[IDX_W'((int'(ring_front) + cnt) % DEPTH)] = item.value;
                    end
                    ring_count = ring_count + (IDX_W+1)'(1);
                    expect_result('0, STS_OK, 1'b0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (cnt == 0) begin
                    expect_result('0, STS_EMPTY, 1'b0, 1'b1);
                end else begin
                    if (item.opcode == OP_POP_FRONT)
                        ring_front = IDX_W'((int'(ring_front) + 1) % DEPTH);
                    ring_count = ring_count - (IDX_W+1)'(1);
                    expect_result('0, STS_OK, 1'b0, 1'b1);
                end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
                if (cnt == 0) begin
                    expect_result('0, STS_EMPTY, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < cnt; i++) begin
                        off = (item.opcode == OP_DUMP_FWD) ? i : cnt - 1 - i;
                        expect_result(ring_store[IDX_W'((int'(ring_front) + off) % DEPTH)],
                                      STS_OK, 1'b1, (i == cnt - 1));
                    end
                end
            end
            default: begin
                expect_result('0, STS_OK, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Drive one input transaction; idles first per the sender profile
    task automatic send_item(input logic [2:0] op, input logic [31:0] val);
        int n_idle;
        t_in item;
        n_idle = 0;
        while ($urandom_range(0, 99) < send_idle_pct) n_idle++;
        item.opcode = op;
        item.value  = val;
        @(negedge i_clk);
        if (n_idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (n_idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_deque(item);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly random values, with the extremes mixed in
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stall per cycle according to the current profile
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic check_result(input t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            report_error($sformatf("unexpected result value_res=%0d status=%0d",
                                   got.value_res, got.status));
        end else begin
            want = pending_results.pop_front();
            if (got.value_res !== want.value_res)
                report_error($sformatf("value_res %0d, expected %0d",
                                       got.value_res, want.value_res));
            if (got.status !== want.status)
                report_error($sformatf("status %0d, expected %0d",
                                       got.status, want.status));
            if (got.has_value !== want.has_value)
                report_error($sformatf("has_value %0b, expected %0b",
                                       got.has_value, want.has_value));
            if (got.last !== want.last)
                report_error($sformatf("last %0b, expected %0b",
                                       got.last, want.last));
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result(o_out_data);
        end
    end

    // Pops and dumps on an empty deque, plus the two spare opcodes
    task automatic test_empty_cases();
        send_item(OP_POP_FRONT, 32'hffff_ffff);
        send_item(OP_POP_BACK,  32'h0000_0000);
        send_item(OP_DUMP_FWD,  32'hffff_ffff);
        send_item(OP_DUMP_REV,  32'h0000_0000);
        send_item(OP_SPARE_6,   32'hffff_ffff);
        send_item(OP_SPARE_7,   32'h0000_0000);
    endtask

    // Extreme values through both ends, dumps in both orders, pops to empty
    task automatic test_value_extremes();
        send_item(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_item(OP_PUSH_BACK,  32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'h0000_0000);
        send_item(OP_PUSH_BACK,  32'hffff_ffff);
        send_item(OP_PUSH_FRONT, 32'h0000_0001);
        send_item(OP_DUMP_FWD,   32'h1234_5678);
        send_item(OP_DUMP_REV,   32'h1234_5678);
        send_item(OP_POP_FRONT,  32'hffff_ffff);
        send_item(OP_POP_BACK,   32'hffff_ffff);
        send_item(OP_DUMP_FWD,   32'h0);
        send_item(OP_POP_FRONT,  32'h0);
        send_item(OP_POP_BACK,   32'h0);
        send_item(OP_DUMP_REV,   32'h0);
        send_item(OP_POP_FRONT,  32'h0);
        send_item(OP_POP_BACK,   32'h0);
    endtask

    // Fill to full from random ends, overflow, dump, then drain to empty
    task automatic test_fill_drain();
        while (ring_count < DEPTH)
            send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_value());
        send_item(OP_PUSH_FRONT, rand_value());
        send_item(OP_PUSH_BACK,  rand_value());
        send_item(OP_DUMP_FWD,   rand_value());
        send_item(OP_DUMP_REV,   rand_value());
        while (ring_count > 0) begin
            send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_value());
            if ($urandom_range(0, 3) == 0)
                send_item($urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD, rand_value());
        end
        send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_value());
    endtask

    // Weighted random mix of every opcode
    task automatic test_random_mix(input int n_items);
        int pick;
        logic [2:0] op;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (pick < 72)
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            else if (pick < 95)
                op = $urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD;
            else
                op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            send_item(op, rand_value());
        end
    endtask

    // Main sequence
    initial begin
        for (int i = 0; i < DEPTH; i++) ring_store[i] = '0;
        ring_front = '0;
        ring_count = '0;

        // Synchronous reset
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cases();
        test_value_extremes();
        drain_results();

        // Idle profiles: none, sender, receiver, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 25 : 0;
            recv_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 25 : 0;
            test_fill_drain();
            test_random_mix(55);
            drain_results();
        end

        // Let any stray result surface
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
